/* hdl/pas_pkg.sv */
// shared types and constants for the polyline area simplifier
// no dependencies; imported by pas_area and polyline_area_simplifier_core
package pas_pkg;

  localparam int COORD_W   = 24;
  localparam int AREA_W    = 50;
  localparam int IDX_OUT_W = 6;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int SUM_W     = PROD_W + 1;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } pas_in_t;

  typedef struct packed {
    logic                 keep_point;
    logic [IDX_OUT_W-1:0] point_index;
    logic                 last_result;
    logic                 overflow;
  } pas_out_t;

  // three vertices of one triangle, a and c around b
  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } pas_tri_t;

endpackage

/* hdl/pas_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module pas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pas_area.sv */
// three stage doubled triangle area unit, saturated to the area width
// depends on pas_pkg
module pas_area
  import pas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  pas_tri_t          tri_in,
  output logic              done,
  output logic [AREA_W-1:0] area
);

  logic signed [DIFF_W-1:0] d1_r, d2_r, d3_r, d4_r;
  logic signed [PROD_W-1:0] p1_r, p2_r;
  logic                     v1_r, v2_r, v3_r;
  logic [AREA_W-1:0]        area_r;
  logic signed [SUM_W-1:0]  diff;
  logic [SUM_W-1:0]         mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    diff = SUM_W'(p1_r) - SUM_W'(p2_r);
    mag  = diff[SUM_W-1] ? SUM_W'(-diff) : SUM_W'(diff);
  end

  always_ff @(posedge clk) begin
    // edge vectors from a
    d1_r <= DIFF_W'(tri_in.bx) - DIFF_W'(tri_in.ax);
    d2_r <= DIFF_W'(tri_in.cy) - DIFF_W'(tri_in.ay);
    d3_r <= DIFF_W'(tri_in.cx) - DIFF_W'(tri_in.ax);
    d4_r <= DIFF_W'(tri_in.by) - DIFF_W'(tri_in.ay);
    p1_r <= d1_r * d2_r;
    p2_r <= d3_r * d4_r;
    area_r <= (|mag[SUM_W-1:AREA_W]) ? AREA_MAX : mag[AREA_W-1:0];
  end

  assign done = v3_r;
  assign area = area_r;

endmodule

/* hdl/polyline_area_simplifier_core.sv */
// polyline area simplifier: Visvalingam-Whyatt removal of low-area vertices.
// Vertices stream in one per cycle and are stored in a coordinate ram; the
// transfer carrying last_point starts the run. If the last vertex sorts below
// the first (x, then y, signed) the chain is walked in reverse. Per vertex a
// link/area ram holds previous link, next link and effective doubled area.
// Setup reads each vertex once and computes the interior areas. Each removal
// then scans all interior entries through the single read port of the
// link/area ram and patches both neighbors.
// Keep flags leave one per cycle while out_ready is high, in original load
// order, with point_index, last_result on the final vertex and overflow if
// vertices beyond MAX_POINTS were dropped. Input is not taken while a run is
// busy. Accesses to the same ram entry are strictly sequenced by the
// controller, so no forwarding is needed. The user must write the tolerance
// register only while the block is idle; the block itself does not enforce
// this.
module polyline_area_simplifier_core
  import pas_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [AREA_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  pas_in_t           in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output pas_out_t          out_item
);

  localparam int IW     = $clog2(MAX_POINTS);
  localparam int INFO_W = 2 * IW + AREA_W;
  localparam int XY_W   = 2 * COORD_W;

  typedef enum logic [16:0] {
    S_LOAD     = 17'h00001,
    S_START    = 17'h00002,
    S_I_RD     = 17'h00004,
    S_I_CAP    = 17'h00008,
    S_I_AW     = 17'h00010,
    S_I_END    = 17'h00020,
    S_SCAN     = 17'h00040,
    S_SCAN_END = 17'h00080,
    S_DECIDE   = 17'h00100,
    S_N_RD     = 17'h00200,
    S_N_CAP    = 17'h00400,
    S_C_RD     = 17'h00800,
    S_C_CAP    = 17'h01000,
    S_N_AW     = 17'h02000,
    S_N_WR     = 17'h04000,
    S_OUT      = 17'h08000,
    S_SPARE    = 17'h10000
  } state_t;

  state_t state_r;

  logic [AREA_W-1:0]         tol_r;
  logic [IW:0]               cnt_r, n_r, p_r, k_r;
  logic                      ovf_r, rev_r;
  logic signed [COORD_W-1:0] fx_r, fy_r, lx_r, ly_r;
  pas_tri_t                  win_r;
  logic                      area_go_r;
  logic [IW-1:0]             q_r, qd_r, best_r, bprev_r, bnext_r, v_r;
  logic                      scan_vld_r, found_r, nb_sel_r;
  logic [AREA_W-1:0]         best_area_r, last_rem_r;
  logic [MAX_POINTS-1:0]     kept_r;
  logic [IW-1:0]             np_r, nn_r, c0_r, c1_r, c2_r;
  logic [AREA_W-1:0]         narea_r;
  logic [1:0]                j_r;
  logic                      out_valid_r;
  pas_out_t                  out_item_r;

  // ram ports
  logic              xy_we;
  logic [IW-1:0]     xy_waddr, xy_raddr;
  logic [XY_W-1:0]   xy_wdata, xy_rdata;
  logic              inf_we;
  logic [IW-1:0]     inf_waddr, inf_raddr;
  logic [INFO_W-1:0] inf_wdata, inf_rdata;

  logic              area_done;
  logic [AREA_W-1:0] area_res;

  logic [IW-1:0]             rd_prev, rd_next;
  logic [AREA_W-1:0]         rd_area;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic [IW:0]               n_m1, n_m2;
  logic                      in_xfer, out_xfer, store_ok;

  // processing position to load-order address
  function automatic logic [IW-1:0] orig(input logic [IW-1:0] p, input logic [IW:0] n,
                                         input logic rev);
    logic [IW:0] t;
    t = n - {1'b0, p} - (IW+1)'(1);
    return rev ? t[IW-1:0] : p;
  endfunction

  assign rd_prev = inf_rdata[INFO_W-1 -: IW];
  assign rd_next = inf_rdata[AREA_W +: IW];
  assign rd_area = inf_rdata[AREA_W-1:0];
  assign rd_x    = xy_rdata[XY_W-1 -: COORD_W];
  assign rd_y    = xy_rdata[COORD_W-1:0];
  assign n_m1    = n_r - (IW+1)'(1);
  assign n_m2    = n_r - (IW+1)'(2);

  assign in_ready  = (state_r == S_LOAD);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_xfer  = out_valid_r && out_ready;
  assign store_ok  = (cnt_r < (IW+1)'(MAX_POINTS));

  // coordinate ram: one vertex per entry in load order
  assign xy_we    = in_xfer && store_ok;
  assign xy_waddr = cnt_r[IW-1:0];
  assign xy_wdata = {in_item.point_x, in_item.point_y};
  always_comb begin
    case (state_r)
      S_I_RD:  xy_raddr = orig(p_r[IW-1:0], n_r, rev_r);
      S_C_RD:  xy_raddr = orig(c0_r, n_r, rev_r);
      default: xy_raddr = '0;
    endcase
  end

  // link/area ram writes, one source per state
  always_comb begin
    inf_we    = 1'b0;
    inf_waddr = v_r;
    inf_wdata = {np_r, nn_r, narea_r};
    case (state_r)
      S_I_CAP: begin
        inf_we    = (p_r == '0);
        inf_waddr = '0;
        inf_wdata = {IW'(0), IW'(1), AREA_W'(0)};
      end
      S_I_AW: begin
        inf_we    = area_done;
        inf_waddr = IW'(p_r - (IW+1)'(1));
        inf_wdata = {IW'(p_r - (IW+1)'(2)), p_r[IW-1:0], area_res};
      end
      S_I_END: begin
        inf_we    = 1'b1;
        inf_waddr = n_m1[IW-1:0];
        inf_wdata = {n_m2[IW-1:0], IW'(0), AREA_W'(0)};
      end
      S_N_WR: begin
        inf_we = 1'b1;
      end
      default: begin
        inf_we = 1'b0;
      end
    endcase
  end
  assign inf_raddr = (state_r == S_SCAN) ? q_r : v_r;

  pas_ram #(.WIDTH(XY_W), .DEPTH(MAX_POINTS)) u_xy_ram (
    .clk   (clk),
    .we    (xy_we),
    .waddr (xy_waddr),
    .wdata (xy_wdata),
    .raddr (xy_raddr),
    .rdata (xy_rdata)
  );

  pas_ram #(.WIDTH(INFO_W), .DEPTH(MAX_POINTS)) u_info_ram (
    .clk   (clk),
    .we    (inf_we),
    .waddr (inf_waddr),
    .wdata (inf_wdata),
    .raddr (inf_raddr),
    .rdata (inf_rdata)
  );

  pas_area u_area (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (area_go_r),
    .tri_in (win_r),
    .done   (area_done),
    .area   (area_res)
  );

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // run controller
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      kept_r      <= '1;
      area_go_r   <= 1'b0;
      scan_vld_r  <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      last_rem_r  <= '0;
    end else begin
      area_go_r <= 1'b0;

      // scan compare, one entry per cycle behind the ram read
      if (scan_vld_r && kept_r[qd_r] && (!found_r || rd_area < best_area_r)) begin
        found_r     <= 1'b1;
        best_r      <= qd_r;
        best_area_r <= rd_area;
        bprev_r     <= rd_prev;
        bnext_r     <= rd_next;
      end

      case (state_r)
        S_LOAD: begin
          if (in_xfer) begin
            if (store_ok) begin
              cnt_r <= cnt_r + (IW+1)'(1);
              lx_r  <= in_item.point_x;
              ly_r  <= in_item.point_y;
              if (cnt_r == '0) begin
                fx_r <= in_item.point_x;
                fy_r <= in_item.point_y;
              end
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_item.last_point) begin
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          n_r        <= cnt_r;
          rev_r      <= (lx_r < fx_r) || ((lx_r == fx_r) && (ly_r < fy_r));
          last_rem_r <= '0;
          p_r        <= '0;
          k_r        <= '0;
          state_r    <= (cnt_r < (IW+1)'(3)) ? S_OUT : S_I_RD;
        end
        S_I_RD: begin
          state_r <= S_I_CAP;
        end
        S_I_CAP: begin
          win_r.ax <= win_r.bx;
          win_r.ay <= win_r.by;
          win_r.bx <= win_r.cx;
          win_r.by <= win_r.cy;
          win_r.cx <= rd_x;
          win_r.cy <= rd_y;
          if (p_r >= (IW+1)'(2)) begin
            area_go_r <= 1'b1;
            state_r   <= S_I_AW;
          end else begin
            p_r     <= p_r + (IW+1)'(1);
            state_r <= S_I_RD;
          end
        end
        S_I_AW: begin
          if (area_done) begin
            p_r     <= p_r + (IW+1)'(1);
            state_r <= (p_r == n_m1) ? S_I_END : S_I_RD;
          end
        end
        S_I_END: begin
          q_r     <= IW'(1);
          found_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          scan_vld_r <= 1'b1;
          qd_r       <= q_r;
          q_r        <= q_r + IW'(1);
          if ({1'b0, q_r} == n_m2) begin
            state_r <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          scan_vld_r <= 1'b0;
          state_r    <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!found_r || best_area_r >= tol_r) begin
            state_r <= S_OUT;
          end else begin
            kept_r[best_r] <= 1'b0;
            last_rem_r     <= best_area_r;
            nb_sel_r       <= 1'b0;
            v_r            <= bprev_r;
            state_r        <= S_N_RD;
          end
        end
        S_N_RD: begin
          state_r <= S_N_CAP;
        end
        S_N_CAP: begin
          // splice the removed vertex out of the chain
          np_r    <= nb_sel_r ? bprev_r : rd_prev;
          nn_r    <= nb_sel_r ? rd_next : bnext_r;
          narea_r <= rd_area;
          c0_r    <= nb_sel_r ? bprev_r : rd_prev;
          c1_r    <= v_r;
          c2_r    <= nb_sel_r ? rd_next : bnext_r;
          j_r     <= '0;
          if (v_r != '0 && {1'b0, v_r} < n_m1 && kept_r[v_r]) begin
            state_r <= S_C_RD;
          end else begin
            state_r <= S_N_WR;
          end
        end
        S_C_RD: begin
          state_r <= S_C_CAP;
        end
        S_C_CAP: begin
          win_r.ax <= win_r.bx;
          win_r.ay <= win_r.by;
          win_r.bx <= win_r.cx;
          win_r.by <= win_r.cy;
          win_r.cx <= rd_x;
          win_r.cy <= rd_y;
          c0_r     <= c1_r;
          c1_r     <= c2_r;
          j_r      <= j_r + 2'd1;
          if (j_r == 2'd2) begin
            area_go_r <= 1'b1;
            state_r   <= S_N_AW;
          end else begin
            state_r <= S_C_RD;
          end
        end
        S_N_AW: begin
          if (area_done) begin
            narea_r <= (area_res > last_rem_r) ? area_res : last_rem_r;
            state_r <= S_N_WR;
          end
        end
        S_N_WR: begin
          if (!nb_sel_r) begin
            nb_sel_r <= 1'b1;
            v_r      <= bnext_r;
            state_r  <= S_N_RD;
          end else begin
            q_r     <= IW'(1);
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            if (k_r < n_r) begin
              out_valid_r            <= 1'b1;
              out_item_r.keep_point  <= kept_r[orig(k_r[IW-1:0], n_r, rev_r)];
              out_item_r.point_index <= IDX_OUT_W'(k_r);
              out_item_r.last_result <= (k_r == n_m1);
              out_item_r.overflow    <= ovf_r;
              k_r                    <= k_r + (IW+1)'(1);
            end else begin
              out_valid_r <= 1'b0;
              kept_r      <= '1;
              cnt_r       <= '0;
              ovf_r       <= 1'b0;
              state_r     <= S_LOAD;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT))
    else $error("result valid outside output phase");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid_r))
    else $error("input taken while results pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (IW+1)'(MAX_POINTS))
    else $error("vertex count beyond capacity");

  a_area_owner: assert property (@(posedge clk) disable iff (!rst_n)
    area_done |-> (state_r == S_I_AW || state_r == S_N_AW))
    else $error("area result with no waiting consumer");

  a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && found_r && best_area_r < tol_r) |=>
      (state_r == S_N_RD && !kept_r[best_r]))
    else $error("removal did not clear keep flag");
`endif

endmodule
